@@ rtl/convolution_3x3_rgba_top_defines.svh @@
// assertion macros shared by the convolution rtl files
// no dependencies; included by the modules that carry assertions
`ifndef CONVOLUTION_3X3_RGBA_TOP_DEFINES_SVH
`define CONVOLUTION_3X3_RGBA_TOP_DEFINES_SVH

// same-cycle implication, muted during reset
`define CV3_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, muted during reset
`define CV3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// invariant, muted during reset
`define CV3_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

@@ rtl/cv3_pkg.sv @@
// shared constants, register codes and beat types of the 3x3 rgba convolution
// no dependencies; used by the top level, cv3_lane and cv3_outq
`default_nettype none

package cv3_pkg;

   localparam int KERNEL_SIZE    = 3;
   localparam int TAPS           = KERNEL_SIZE * KERNEL_SIZE;
   localparam int FRAC_BITS      = 8;
   localparam int PIX_BITS       = 8;
   localparam int NUM_LANES      = 4;
   localparam int PIXEL_BITS     = PIX_BITS * NUM_LANES;
   localparam int SIZE_BITS      = 12;
   localparam int ROW_BITS       = 48;
   localparam int POS_BITS       = 11;
   localparam int MIN_SIZE       = 3;
   localparam int PIX_MAX        = 255;
   localparam int RESET_WIDTH    = 640;
   localparam int RESET_HEIGHT   = 480;
   localparam int CSR_ADDR_BITS  = 6;
   localparam int CSR_DATA_BITS  = 64;
   localparam int OUTQ_DEPTH     = 4;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;
   localparam int DEF_COEF_BITS  = 16;
   localparam int DEF_CHANNELS   = 4;

   typedef enum logic [2:0] {
      REG_IMAGE_WIDTH   = 3'd0,
      REG_IMAGE_HEIGHT  = 3'd1,
      REG_KERNEL_TOP    = 3'd2,
      REG_KERNEL_MIDDLE = 3'd3,
      REG_KERNEL_BOTTOM = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] red;
      logic [PIX_BITS-1:0] green;
      logic [PIX_BITS-1:0] blue;
      logic [PIX_BITS-1:0] alpha;
      logic [POS_BITS-1:0] column;
      logic [POS_BITS-1:0] row;
      logic                last;
   } rsp_beat_type;

   typedef struct packed {
      logic first_valid;
      logic second_valid;
   } push_ctl_type;

endpackage

`default_nettype wire

@@ rtl/convolution_3x3_rgba_top.sv @@
// top level of the 3x3 rgba convolution: csr block, position counters, line stores,
// window, channel lanes, merge and result queue; depends on cv3_pkg, cv3_ram,
// cv3_lane, cv3_outq and convolution_3x3_rgba_top_defines.svh
`default_nettype none
`include "convolution_3x3_rgba_top_defines.svh"

// 3x3 true convolution of an rgba raster stream. pixels enter in raster order, one beat
// per clock while not stalled, with frame_start on the first pixel of a frame. border
// pixels come out unchanged; an interior pixel comes out once its lower-right neighbour
// has entered, filtered on all four channels with signed q7.8 coefficients, fraction
// dropped and clamped to 0..255. every result beat carries its column and row, and
// last_of_run marks the final beat caused by one input pixel (an interior result comes
// before the border result of the same input). the pixel path is a five stage pipeline
// (position and line store read, window, products, partial sums, clamp) feeding a
// four-beat result queue. input is stalled only while the queue lacks room for two
// beats, which the result port, popping one beat per clock while not stalled, sets:
// pixels on the right column or bottom row, from the third row and column on, cause
// two beats. the line stores need no clearing pass.
// csr writes must be issued only while the block is idle.
module convolution_3x3_rgba_top #(
   parameter int MAX_WIDTH  = cv3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cv3_pkg::DEF_MAX_HEIGHT,
   parameter int COEF_BITS  = cv3_pkg::DEF_COEF_BITS,
   parameter int CHANNELS   = cv3_pkg::DEF_CHANNELS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // pixel input channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [cv3_pkg::PIX_BITS-1:0]      req_in_red,
   input  wire logic [cv3_pkg::PIX_BITS-1:0]      req_in_green,
   input  wire logic [cv3_pkg::PIX_BITS-1:0]      req_in_blue,
   input  wire logic [cv3_pkg::PIX_BITS-1:0]      req_in_alpha,
   input  wire logic                              req_frame_start,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [cv3_pkg::PIX_BITS-1:0]      rsp_out_red,
   output logic      [cv3_pkg::PIX_BITS-1:0]      rsp_out_green,
   output logic      [cv3_pkg::PIX_BITS-1:0]      rsp_out_blue,
   output logic      [cv3_pkg::PIX_BITS-1:0]      rsp_out_alpha,
   output logic      [cv3_pkg::POS_BITS-1:0]      rsp_out_column,
   output logic      [cv3_pkg::POS_BITS-1:0]      rsp_out_row,
   output logic                                   rsp_last_of_run,
   // csr port
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [cv3_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [cv3_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [cv3_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                                   csr_pready
);

   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int WSZ_W     = $clog2(MAX_WIDTH + 1);
   localparam int HSZ_W     = $clog2(MAX_HEIGHT + 1);
   localparam int PX_W      = cv3_pkg::PIXEL_BITS;
   localparam int PB        = cv3_pkg::PIX_BITS;
   localparam int KS        = cv3_pkg::KERNEL_SIZE;
   localparam int TAPS      = cv3_pkg::TAPS;
   localparam int ROW_EXT_W = (KS * COEF_BITS > cv3_pkg::ROW_BITS) ?
                              KS * COEF_BITS : cv3_pkg::ROW_BITS;
   localparam logic [cv3_pkg::ROW_BITS-1:0] KERNEL_MID_RESET =
      cv3_pkg::ROW_BITS'(1) << (COEF_BITS + cv3_pkg::FRAC_BITS);

   // ---------------------------------------------------------------- csr block
   logic [cv3_pkg::SIZE_BITS-1:0] image_width_ff, image_height_ff;
   logic [cv3_pkg::ROW_BITS-1:0]  kernel_ff [KS];
   logic                          csr_wr;
   cv3_pkg::reg_index_type        csr_index;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = cv3_pkg::reg_index_type'(csr_paddr[cv3_pkg::CSR_ADDR_BITS-1:3]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= cv3_pkg::SIZE_BITS'(cv3_pkg::RESET_WIDTH);
         image_height_ff <= cv3_pkg::SIZE_BITS'(cv3_pkg::RESET_HEIGHT);
         kernel_ff[0]    <= '0;
         kernel_ff[1]    <= KERNEL_MID_RESET;
         kernel_ff[2]    <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            cv3_pkg::REG_IMAGE_WIDTH: begin
               image_width_ff <= csr_pwdata[cv3_pkg::SIZE_BITS-1:0];
            end
            cv3_pkg::REG_IMAGE_HEIGHT: begin
               image_height_ff <= csr_pwdata[cv3_pkg::SIZE_BITS-1:0];
            end
            cv3_pkg::REG_KERNEL_TOP: begin
               kernel_ff[0] <= csr_pwdata[cv3_pkg::ROW_BITS-1:0];
            end
            cv3_pkg::REG_KERNEL_MIDDLE: begin
               kernel_ff[1] <= csr_pwdata[cv3_pkg::ROW_BITS-1:0];
            end
            cv3_pkg::REG_KERNEL_BOTTOM: begin
               kernel_ff[2] <= csr_pwdata[cv3_pkg::ROW_BITS-1:0];
            end
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         cv3_pkg::REG_IMAGE_WIDTH:   csr_prdata = cv3_pkg::CSR_DATA_BITS'(image_width_ff);
         cv3_pkg::REG_IMAGE_HEIGHT:  csr_prdata = cv3_pkg::CSR_DATA_BITS'(image_height_ff);
         cv3_pkg::REG_KERNEL_TOP:    csr_prdata = cv3_pkg::CSR_DATA_BITS'(kernel_ff[0]);
         cv3_pkg::REG_KERNEL_MIDDLE: csr_prdata = cv3_pkg::CSR_DATA_BITS'(kernel_ff[1]);
         cv3_pkg::REG_KERNEL_BOTTOM: csr_prdata = cv3_pkg::CSR_DATA_BITS'(kernel_ff[2]);
         default:                    csr_prdata = '0;
      endcase
   end

   // effective frame size: below three acts as three, above the maximum as the maximum
   logic [WSZ_W-1:0] width_eff;
   logic [HSZ_W-1:0] height_eff;

   always_comb begin
      if (image_width_ff < cv3_pkg::SIZE_BITS'(cv3_pkg::MIN_SIZE)) begin
         width_eff = WSZ_W'(cv3_pkg::MIN_SIZE);
      end else if (32'(image_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WSZ_W'(MAX_WIDTH);
      end else begin
         width_eff = WSZ_W'(image_width_ff);
      end
      if (image_height_ff < cv3_pkg::SIZE_BITS'(cv3_pkg::MIN_SIZE)) begin
         height_eff = HSZ_W'(cv3_pkg::MIN_SIZE);
      end else if (32'(image_height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = HSZ_W'(MAX_HEIGHT);
      end else begin
         height_eff = HSZ_W'(image_height_ff);
      end
   end

   // coefficient k sits in row k/3, field k%3; bits above the row read as zero
   logic [ROW_EXT_W-1:0]             row_ext [KS];
   logic [TAPS-1:0][COEF_BITS-1:0]   coefs;

   for (genvar j = 0; j < KS; j++) begin : g_row
      assign row_ext[j] = ROW_EXT_W'(kernel_ff[j]);
   end
   for (genvar k = 0; k < TAPS; k++) begin : g_coef
      assign coefs[k] = row_ext[k / KS][(k % KS) * COEF_BITS +: COEF_BITS];
   end

   // ---------------------------------------------------------------- pipeline control
   // the whole pipe moves together; it holds only when the last stage holds a valid pixel
   // and the queue cannot take two beats
   logic pipe_en, accept, queue_room;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;

   assign pipe_en   = !s5_valid_ff || queue_room;
   assign req_stall = !pipe_en;
   assign accept    = req_valid && pipe_en;

   // ---------------------------------------------------------------- position counters
   logic [COL_W-1:0] col_ff, col_in, col_cur;
   logic [ROW_W-1:0] row_ff, row_in, row_cur;
   logic [COL_W-1:0] col_start;
   logic [HSZ_W-1:0] row_start;
   logic [WSZ_W-1:0] col_plus;
   logic [HSZ_W-1:0] row_plus;

   always_comb begin
      // frame_start puts this pixel at the origin
      col_start = req_frame_start ? '0 : col_ff;
      row_start = req_frame_start ? '0 : HSZ_W'(row_ff);
      // a column left past the width by a size change starts the next row
      if (WSZ_W'(col_start) >= width_eff) begin
         col_start = '0;
         row_start = row_start + HSZ_W'(1);
      end
      if (row_start >= height_eff) begin
         row_start = '0;
      end
      col_cur = col_start;
      row_cur = ROW_W'(row_start);
      // position of the following pixel
      col_plus = WSZ_W'(col_cur) + WSZ_W'(1);
      row_plus = HSZ_W'(row_cur);
      if (col_plus >= width_eff) begin
         col_plus = '0;
         row_plus = row_plus + HSZ_W'(1);
         if (row_plus >= height_eff) begin
            row_plus = '0;
         end
      end
      col_in = COL_W'(col_plus);
      row_in = ROW_W'(row_plus);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- stage 1: line stores
   logic [PX_W-1:0]  s1_px_ff, s1_fwd_up_ff, s1_fwd_lo_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_fwd_ff;
   logic [PX_W-1:0]  ram_up_rd, ram_lo_rd, s1_up_eff, s1_lo_eff;
   logic             s1_move, s1_interior, s1_border;

   assign s1_move   = s1_valid_ff && pipe_en;
   // same column read again right behind its own write: take the values in flight
   assign s1_up_eff = s1_fwd_ff ? s1_fwd_up_ff : ram_up_rd;
   assign s1_lo_eff = s1_fwd_ff ? s1_fwd_lo_ff : ram_lo_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff     <= {req_in_alpha, req_in_blue, req_in_green, req_in_red};
         s1_col_ff    <= col_cur;
         s1_row_ff    <= row_cur;
         s1_fwd_ff    <= s1_valid_ff && (s1_col_ff == col_cur);
         s1_fwd_up_ff <= s1_lo_eff;
         s1_fwd_lo_ff <= s1_px_ff;
      end
   end

   // upper store gets the old lower row, lower store gets the new pixel
   cv3_ram #(
      .WIDTH   (PX_W),
      .DEPTH   (MAX_WIDTH)
   ) u_line_upper (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (s1_lo_eff),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (ram_up_rd)
   );

   cv3_ram #(
      .WIDTH   (PX_W),
      .DEPTH   (MAX_WIDTH)
   ) u_line_lower (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (s1_col_ff),
      .wr_data (s1_px_ff),
      .rd_en   (accept),
      .rd_addr (col_cur),
      .rd_data (ram_lo_rd)
   );

   assign s1_interior = (s1_col_ff >= COL_W'(2)) && (s1_row_ff >= ROW_W'(2));
   assign s1_border   = (s1_col_ff == '0) || (s1_row_ff == '0)
                     || (WSZ_W'(s1_col_ff) == WSZ_W'(width_eff - WSZ_W'(1)))
                     || (HSZ_W'(s1_row_ff) == HSZ_W'(height_eff - HSZ_W'(1)));

   // ---------------------------------------------------------------- stage 2: window
   // three rows by three columns, newest column on the right, current pixel bottom right
   logic [PX_W-1:0]  win_ff [TAPS];
   logic [COL_W-1:0] s2_col_ff, s3_col_ff, s4_col_ff, s5_col_ff;
   logic [ROW_W-1:0] s2_row_ff, s3_row_ff, s4_row_ff, s5_row_ff;
   logic             s2_int_ff, s3_int_ff, s4_int_ff, s5_int_ff;
   logic             s2_bor_ff, s3_bor_ff, s4_bor_ff, s5_bor_ff;
   logic [PX_W-1:0]  s3_px_ff, s4_px_ff, s5_px_ff;
   logic [PX_W-1:0]  s3_ctr_ff, s4_ctr_ff, s5_ctr_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         for (int rr = 0; rr < KS; rr++) begin
            win_ff[rr*KS]     <= win_ff[rr*KS + 1];
            win_ff[rr*KS + 1] <= win_ff[rr*KS + 2];
         end
         win_ff[KS - 1]      <= s1_up_eff;
         win_ff[2*KS - 1]    <= s1_lo_eff;
         win_ff[TAPS - 1]    <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // position, flags and the raw pixels ride alongside the lanes
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_col_ff <= s1_col_ff;
         s2_row_ff <= s1_row_ff;
         s2_int_ff <= s1_interior;
         s2_bor_ff <= s1_border;
         s3_col_ff <= s2_col_ff;
         s3_row_ff <= s2_row_ff;
         s3_int_ff <= s2_int_ff;
         s3_bor_ff <= s2_bor_ff;
         s3_px_ff  <= win_ff[TAPS - 1];
         s3_ctr_ff <= win_ff[TAPS / 2];
         s4_col_ff <= s3_col_ff;
         s4_row_ff <= s3_row_ff;
         s4_int_ff <= s3_int_ff;
         s4_bor_ff <= s3_bor_ff;
         s4_px_ff  <= s3_px_ff;
         s4_ctr_ff <= s3_ctr_ff;
         s5_col_ff <= s4_col_ff;
         s5_row_ff <= s4_row_ff;
         s5_int_ff <= s4_int_ff;
         s5_bor_ff <= s4_bor_ff;
         s5_px_ff  <= s4_px_ff;
         s5_ctr_ff <= s4_ctr_ff;
      end
   end

   // ---------------------------------------------------------------- stages 3-5: lanes
   // coefficient k weights the window tap mirrored through the centre
   logic [PB-1:0] conv_byte [cv3_pkg::NUM_LANES];

   for (genvar ch = 0; ch < cv3_pkg::NUM_LANES; ch++) begin : g_lane
      if (ch < CHANNELS) begin : g_active
         logic [TAPS-1:0][PB-1:0] lane_pix;
         for (genvar k = 0; k < TAPS; k++) begin : g_tap
            assign lane_pix[k] = win_ff[TAPS - 1 - k][ch*PB +: PB];
         end
         cv3_lane #(
            .COEF_BITS (COEF_BITS)
         ) u_lane (
            .clock     (clock),
            .en        (pipe_en),
            .pix       (lane_pix),
            .coefs     (coefs),
            .result    (conv_byte[ch])
         );
      end else begin : g_pass
         // channel not filtered: centre pixel passes
         assign conv_byte[ch] = s5_ctr_ff[ch*PB +: PB];
      end
   end

   // ---------------------------------------------------------------- merge and queue
   cv3_pkg::push_ctl_type push_ctl;
   cv3_pkg::rsp_beat_type beat_interior, beat_border, beat_out;

   assign push_ctl.first_valid  = s5_valid_ff && s5_int_ff && pipe_en;
   assign push_ctl.second_valid = s5_valid_ff && s5_bor_ff && pipe_en;

   always_comb begin
      // interior result sits one up and one left of the pixel that released it
      beat_interior.red    = conv_byte[0];
      beat_interior.green  = conv_byte[1];
      beat_interior.blue   = conv_byte[2];
      beat_interior.alpha  = conv_byte[3];
      beat_interior.column = cv3_pkg::POS_BITS'(s5_col_ff - COL_W'(1));
      beat_interior.row    = cv3_pkg::POS_BITS'(s5_row_ff - ROW_W'(1));
      beat_interior.last   = !s5_bor_ff;
      // border pixel goes out as it came in
      beat_border.red      = s5_px_ff[0*PB +: PB];
      beat_border.green    = s5_px_ff[1*PB +: PB];
      beat_border.blue     = s5_px_ff[2*PB +: PB];
      beat_border.alpha    = s5_px_ff[3*PB +: PB];
      beat_border.column   = cv3_pkg::POS_BITS'(s5_col_ff);
      beat_border.row      = cv3_pkg::POS_BITS'(s5_row_ff);
      beat_border.last     = 1'b1;
   end

   cv3_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .push_ctl    (push_ctl),
      .beat_first  (beat_interior),
      .beat_second (beat_border),
      .has_room    (queue_room),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_beat    (beat_out)
   );

   assign rsp_out_red     = beat_out.red;
   assign rsp_out_green   = beat_out.green;
   assign rsp_out_blue    = beat_out.blue;
   assign rsp_out_alpha   = beat_out.alpha;
   assign rsp_out_column  = beat_out.column;
   assign rsp_out_row     = beat_out.row;
   assign rsp_last_of_run = beat_out.last;

   `CV3_ASSERT_IMPLY(a_col_in_frame, clock, reset, s1_valid_ff, WSZ_W'(s1_col_ff) < width_eff, "stage 1 column outside frame width")
   `CV3_ASSERT_IMPLY(a_interior_col, clock, reset, s5_valid_ff && s5_int_ff, (s5_col_ff >= COL_W'(2)) && (s5_row_ff >= ROW_W'(2)), "interior result without full window")
   `CV3_ASSERT_NEXT(a_stage_advance, clock, reset, s1_valid_ff && pipe_en, s2_valid_ff, "stage 1 beat lost on advance")
   `CV3_ASSERT_IMPLY(a_fwd_valid, clock, reset, s1_valid_ff && s1_fwd_ff, s1_col_ff == '0, "line store bypass away from column zero")

endmodule

`default_nettype wire

@@ rtl/cv3_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies; holds the two line stores
`default_nettype none

module cv3_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/cv3_lane.sv @@
// one channel lane: nine products, partial sums of three, final sum with clamp
// depends on cv3_pkg
`default_nettype none

module cv3_lane #(
   parameter int COEF_BITS = cv3_pkg::DEF_COEF_BITS
) (
   input  wire logic                                              clock,
   input  wire logic                                              en,
   input  wire logic [cv3_pkg::TAPS-1:0][cv3_pkg::PIX_BITS-1:0]   pix,
   input  wire logic [cv3_pkg::TAPS-1:0][COEF_BITS-1:0]           coefs,
   output logic      [cv3_pkg::PIX_BITS-1:0]                      result
);

   localparam int PROD_W = COEF_BITS + cv3_pkg::PIX_BITS + 1;
   localparam int PART_W = PROD_W + 2;
   localparam int SUM_W  = PROD_W + 4;
   localparam int TOP_W  = cv3_pkg::FRAC_BITS + cv3_pkg::PIX_BITS;

   logic signed [PROD_W-1:0]          prod_ff [cv3_pkg::TAPS];
   logic signed [PART_W-1:0]          part_ff [cv3_pkg::KERNEL_SIZE];
   logic        [cv3_pkg::PIX_BITS-1:0] res_ff;
   logic        [cv3_pkg::PIX_BITS-1:0] res_in;
   logic signed [SUM_W-1:0]           sum;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < cv3_pkg::TAPS; k++) begin
            prod_ff[k] <= $signed({1'b0, pix[k]}) * $signed(coefs[k]);
         end
         for (int j = 0; j < cv3_pkg::KERNEL_SIZE; j++) begin
            part_ff[j] <= PART_W'(prod_ff[3*j]) + PART_W'(prod_ff[3*j+1])
                        + PART_W'(prod_ff[3*j+2]);
         end
         res_ff <= res_in;
      end
   end

   // drop the fraction, clamp to the pixel range
   always_comb begin
      sum = SUM_W'(part_ff[0]) + SUM_W'(part_ff[1]) + SUM_W'(part_ff[2]);
      if (sum[SUM_W-1]) begin
         res_in = '0;
      end else if (sum[SUM_W-2:TOP_W] != '0) begin
         res_in = cv3_pkg::PIX_BITS'(cv3_pkg::PIX_MAX);
      end else begin
         res_in = sum[TOP_W-1:cv3_pkg::FRAC_BITS];
      end
   end

   assign result = res_ff;

endmodule

`default_nettype wire

@@ rtl/cv3_outq.sv @@
// result queue: up to two beats pushed per cycle, one popped per cycle while not stalled
// depends on cv3_pkg and convolution_3x3_rgba_top_defines.svh
`default_nettype none
`include "convolution_3x3_rgba_top_defines.svh"

module cv3_outq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cv3_pkg::push_ctl_type push_ctl,
   input  wire cv3_pkg::rsp_beat_type beat_first,
   input  wire cv3_pkg::rsp_beat_type beat_second,
   output logic                       has_room,
   output logic                       out_valid,
   input  wire logic                  out_stall,
   output cv3_pkg::rsp_beat_type      out_beat
);

   localparam int DEPTH = cv3_pkg::OUTQ_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cv3_pkg::rsp_beat_type q_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_ptr_plus;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop         = (count_ff != '0) && !out_stall;
   assign wr_ptr_plus = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      count_in  = count_ff + CNT_W'(push_ctl.first_valid) + CNT_W'(push_ctl.second_valid)
                - CNT_W'(pop);
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_ctl.first_valid) + PTR_W'(push_ctl.second_valid);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ctl.first_valid) begin
         q_ff[wr_ptr_ff] <= beat_first;
      end
      if (push_ctl.second_valid) begin
         q_ff[push_ctl.first_valid ? wr_ptr_plus : wr_ptr_ff] <= beat_second;
      end
   end

   assign has_room  = count_ff <= CNT_W'(DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_beat  = q_ff[rd_ptr_ff];

   `CV3_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH), "queue count exceeds depth")
   `CV3_ASSERT_IMPLY(a_push_room, clock, reset, push_ctl.first_valid || push_ctl.second_valid, count_ff <= CNT_W'(DEPTH - 2), "push without room for two beats")
   `CV3_ASSERT_IMPLY(a_ptr_track, clock, reset, count_ff != CNT_W'(DEPTH), PTR_W'(rd_ptr_ff + PTR_W'(count_ff)) == wr_ptr_ff, "queue pointers disagree with count")

endmodule

`default_nettype wire
